// ===== design/fnq_pkg.sv =====
// ----------------------------------------------------------------------------
// fnq_pkg
// shared types and constants of the feature normalizer and int8 quantizer
// ----------------------------------------------------------------------------
package fnq_pkg;

	localparam int STAT_FEATURES = 32;
	localparam int IDX_W         = 5;
	localparam int TAB_W         = $clog2(STAT_FEATURES);
	localparam int DIV_CELLS     = 32;

	localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_TS    = 2'd1,
		OP_STAT  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		REG_TS_INV   = 2'd0,
		REG_TS_ZP    = 2'd1,
		REG_STAT_INV = 2'd2,
		REG_STAT_ZP  = 2'd3
	} reg_idx_t;

	// word travelling down the divider chain
	typedef struct packed {
		logic        valid;
		logic        is_ts;
		logic [31:0] sample;
		logic        neg;
		logic        ovf;
		logic [31:0] rem;
		logic [31:0] dvd;
		logic [31:0] quo;
		logic [31:0] dvs;
	} div_word_t;

endpackage

// ===== design/fnq_div_cell.sv =====
// ----------------------------------------------------------------------------
// fnq_div_cell
// one restoring division step, one quotient bit per cell
// ----------------------------------------------------------------------------
module fnq_div_cell
	import fnq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  div_word_t din,
	output div_word_t dout
);

	logic [32:0] trial;
	logic        ge;
	div_word_t   nxt;
	div_word_t   word_q;

	always_comb begin
		trial = {din.rem, din.dvd[31]};
		ge    = trial >= {1'b0, din.dvs};
		nxt   = din;
		if (ge) begin
			nxt.rem = 32'(trial - {1'b0, din.dvs});
		end else begin
			nxt.rem = trial[31:0];
		end
		nxt.quo = {din.quo[30:0], ge};
		nxt.dvd = {din.dvd[30:0], 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= '0;
		end else if (en) begin
			word_q <= nxt;
		end
	end

	assign dout = word_q;

endmodule

// ===== design/fnq_quant.sv =====
// ----------------------------------------------------------------------------
// fnq_quant
// saturate quotient, multiply by inverse scale, round half even, clamp
// ----------------------------------------------------------------------------
module fnq_quant
	import fnq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  div_word_t   din,
	input  logic [31:0] ts_inv,
	input  logic [7:0]  ts_zp,
	input  logic [31:0] stat_inv,
	input  logic [7:0]  stat_zp,
	output logic        valid,
	output logic [7:0]  quantized,
	output logic [31:0] normalized
);

	logic [31:0] norm_c;
	logic        valid_s1, valid_s2, valid_s3;
	logic [31:0] norm_s1, norm_s2, norm_s3;
	logic        neg_s1, neg_s2;
	logic [31:0] abs_s1;
	logic [31:0] inv_s1;
	logic [7:0]  zp_s1, zp_s2;
	logic [63:0] prod_s2;
	logic [7:0]  q_s3;

	logic [32:0] ip;
	logic        up;
	logic [34:0] r;
	logic [7:0]  q_c;

	// quotient saturation, time-series words pass their sample
	always_comb begin
		if (din.is_ts) begin
			norm_c = din.sample;
		end else if (!din.neg) begin
			norm_c = (din.ovf || din.quo[31]) ? 32'h7FFF_FFFF : din.quo;
		end else begin
			norm_c = (din.ovf || din.quo > 32'h8000_0000) ? 32'h8000_0000
				: 32'(-din.quo);
		end
	end

	always_comb begin
		ip = {1'b0, prod_s2[63:32]};
		up = prod_s2[31:0] > 32'h8000_0000
			|| (prod_s2[31:0] == 32'h8000_0000 && prod_s2[32]);
		ip = ip + {32'b0, up};
		r  = neg_s2 ? 35'(-$signed({2'b0, ip})) : {2'b0, ip};
		r  = r + {{27{zp_s2[7]}}, zp_s2};
		if ($signed(r) < -35'sd128) begin
			q_c = 8'h80;
		end else if ($signed(r) > 35'sd127) begin
			q_c = 8'h7F;
		end else begin
			q_c = r[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= din.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			norm_s1 <= norm_c;
			neg_s1  <= norm_c[31];
			abs_s1  <= norm_c[31] ? 32'(-norm_c) : norm_c;
			inv_s1  <= din.is_ts ? ts_inv : stat_inv;
			zp_s1   <= din.is_ts ? ts_zp : stat_zp;
			norm_s2 <= norm_s1;
			neg_s2  <= neg_s1;
			zp_s2   <= zp_s1;
			prod_s2 <= 64'(abs_s1) * 64'(inv_s1);
			norm_s3 <= norm_s2;
			q_s3    <= q_c;
		end
	end

	assign valid      = valid_s3;
	assign quantized  = q_s3;
	assign normalized = norm_s3;

endmodule

// ===== design/feature_normalize_quantize_int8_top.sv =====
// ----------------------------------------------------------------------------
// feature_normalize_quantize_int8_top
// z-score normalizer and int8 affine quantizer for q16.16 samples
// ----------------------------------------------------------------------------
// one word per cycle in and out at full rate. a word with tuser 0 loads the
// mean and deviation entry of its feature (no output word), 1 quantizes the
// sample with the time-series scale, 2 subtracts the feature mean, divides
// by its deviation (zero deviation counts as 1.0) with a saturated q16.16
// quotient and quantizes with the statistic scale, 3 is dropped. pipe:
// table read, divider setup, a chain of 32 division cells (one quotient
// bit each), saturation, a 32x32 multiply and the round/clamp register.
// the whole pipe holds on output backpressure, so s_tready follows m_tready
// when a word is waiting. the user must write registers through
// cfg_we/cfg_index/cfg_data while idle; the block does not enforce it.
module feature_normalize_quantize_int8_top
	import fnq_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [103:0] s_tdata,  // feature_index[4:0], sample_value[36:5],
	                               // mean_entry[68:37], deviation_entry[100:69]
	input  logic [1:0]   s_tuser,  // operation[1:0]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [39:0]  m_tdata,  // quantized[7:0], normalized[39:8]
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	// configuration registers
	logic [31:0] ts_inv_q, stat_inv_q;
	logic [7:0]  ts_zp_q, stat_zp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ts_inv_q   <= ONE_Q16;
			ts_zp_q    <= 8'd0;
			stat_inv_q <= ONE_Q16;
			stat_zp_q  <= 8'd0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_TS_INV:   ts_inv_q   <= cfg_data;
				REG_TS_ZP:    ts_zp_q    <= cfg_data[7:0];
				REG_STAT_INV: stat_inv_q <= cfg_data;
				REG_STAT_ZP:  stat_zp_q  <= cfg_data[7:0];
				default:      ;
			endcase
		end
	end

	// whole pipe advances unless the output word is stalled
	logic adv;
	logic accept;
	assign adv      = !(m_tvalid && !m_tready);
	assign s_tready = adv;
	assign accept   = s_tvalid && adv;

	op_t         op_in;
	logic [4:0]  idx_in;
	assign op_in  = op_t'(s_tuser);
	assign idx_in = s_tdata[4:0];

	// statistics tables, written on load words, read registered
	logic [31:0] mean_mem [STAT_FEATURES];
	logic [31:0] dev_mem  [STAT_FEATURES];
	logic [31:0] mean_s1, dev_s1;
	logic        in_range;
	assign in_range = 32'(idx_in) < STAT_FEATURES;

	always_ff @(posedge clk) begin
		if (accept && op_in == OP_LOAD && in_range) begin
			mean_mem[idx_in[TAB_W-1:0]] <= s_tdata[68:37];
			dev_mem[idx_in[TAB_W-1:0]]  <= s_tdata[100:69];
		end
		if (adv) begin
			mean_s1 <= mean_mem[idx_in[TAB_W-1:0]];
			dev_s1  <= dev_mem[idx_in[TAB_W-1:0]];
		end
	end

	// stage 1: sample and kind alongside the table read
	logic        valid_s1, is_ts_s1, range_s1;
	logic [31:0] sample_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= accept && (op_in == OP_TS || op_in == OP_STAT);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			is_ts_s1  <= op_in == OP_TS;
			range_s1  <= in_range;
			sample_s1 <= s_tdata[36:5];
		end
	end

	// stage 2: difference magnitude and divisor, overflow check on top bits
	logic [32:0] diff;
	logic [32:0] mag;
	logic [31:0] dvs;
	logic [31:0] mean_use;
	div_word_t   head;

	always_comb begin
		mean_use = range_s1 ? mean_s1 : 32'd0;
		dvs      = (!range_s1 || dev_s1 == 32'd0) ? ONE_Q16 : dev_s1;
		diff     = {sample_s1[31], sample_s1} - {mean_use[31], mean_use};
		mag      = diff[32] ? 33'(-diff) : diff;
		head.valid  = valid_s1;
		head.is_ts  = is_ts_s1;
		head.sample = sample_s1;
		head.neg    = diff[32];
		head.rem    = {15'd0, mag[32:16]};
		head.ovf    = {15'd0, mag[32:16]} >= dvs;
		head.dvd    = {mag[15:0], 16'd0};
		head.quo    = 32'd0;
		head.dvs    = dvs;
	end

	div_word_t head_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_s2 <= '0;
		end else if (adv) begin
			head_s2 <= head;
		end
	end

	// division chain, quotient bits 31 down to 0
	div_word_t chain [DIV_CELLS+1];
	assign chain[0] = head_s2;

	for (genvar g = 0; g < DIV_CELLS; g++) begin : g_cell
		fnq_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.din    (chain[g]),
			.dout   (chain[g+1])
		);
	end

	// saturation, scaling and output register
	logic [7:0]  q_out;
	logic [31:0] n_out;

	fnq_quant u_quant (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (adv),
		.din        (chain[DIV_CELLS]),
		.ts_inv     (ts_inv_q),
		.ts_zp      (ts_zp_q),
		.stat_inv   (stat_inv_q),
		.stat_zp    (stat_zp_q),
		.valid      (m_tvalid),
		.quantized  (q_out),
		.normalized (n_out)
	);

	assign m_tdata = {n_out, q_out};

endmodule

// ===== design/fnq_checker.sv =====
// ----------------------------------------------------------------------------
// fnq_port_checks
// port level checks of the normalizer and quantizer
// ----------------------------------------------------------------------------
module fnq_port_checks (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata
);

	// stalled output word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("output word changed while stalled");

	// input only blocked by a stalled output word
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("input blocked without output stall");

	// no output word right out of reset
	a_rst: assert property (@(posedge clk)
		!arst_n |=> !m_tvalid)
		else $error("output word right after reset");

endmodule

bind feature_normalize_quantize_int8_top fnq_port_checks u_fnq_port_checks (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== tb/sv/fnq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fnq_checker
// watches both streams, predicts each output word and compares it
// ----------------------------------------------------------------------------
module fnq_checker
	import fnq_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [103:0] s_tdata,
	input  logic [1:0]   s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [39:0]  m_tdata,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	output int           fail_count,
	output int           pending
);

	logic [31:0] ts_inv, stat_inv;
	logic signed [7:0] ts_zp, stat_zp;
	logic signed [31:0] mean_tab [STAT_FEATURES];
	logic [31:0] dev_tab [STAT_FEATURES];
	logic [39:0] expected_words [$];

	assign pending = expected_words.size();

	function automatic logic signed [7:0] quantize(logic signed [31:0] s, logic [31:0] inv,
			logic signed [7:0] zp);
		logic [63:0] mag, prod, ip, frac;
		logic signed [63:0] r;
		mag  = (s < 0) ? 64'(-64'(s)) : 64'(s);
		prod = mag * 64'(inv);
		ip   = prod >> 32;
		frac = {32'd0, prod[31:0]};
		// round half to even
		if (frac > 64'h8000_0000 || (frac == 64'h8000_0000 && ip[0]))
			ip++;
		r = (s < 0) ? -$signed(ip) : $signed(ip);
		r = r + zp;
		if (r < -128) r = -128;
		if (r > 127) r = 127;
		return r[7:0];
	endfunction

	function automatic logic signed [31:0] z_score(logic signed [31:0] s,
			logic signed [31:0] m, logic [31:0] dev);
		logic signed [63:0] diff;
		logic [63:0] mag, d, q;
		diff = 64'(s) - 64'(m);
		mag  = (diff < 0) ? 64'(-diff) : 64'(diff);
		d    = (dev == 0) ? 64'(ONE_Q16) : 64'(dev);
		q    = (mag << 16) / d;
		if (diff < 0) begin
			if (q > 64'h8000_0000) q = 64'h8000_0000;
			return 32'(-q);
		end
		if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
		return q[31:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [4:0] idx;
		logic signed [31:0] s, norm;
		logic [39:0] exp_w;
		if (!arst_n) begin
			ts_inv = ONE_Q16;
			stat_inv = ONE_Q16;
			ts_zp = 0;
			stat_zp = 0;
			fail_count = 0;
			expected_words.delete();
		end else begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
				REG_TS_INV:   ts_inv = cfg_data;
				REG_TS_ZP:    ts_zp = cfg_data[7:0];
				REG_STAT_INV: stat_inv = cfg_data;
				REG_STAT_ZP:  stat_zp = cfg_data[7:0];
				default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				if (expected_words.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected word %h", m_tdata);
				end else begin
					exp_w = expected_words.pop_front();
					if (m_tdata[7:0] !== exp_w[7:0] || m_tdata[39:8] !== exp_w[39:8]) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: quantized exp %h got %h, normalized exp %h got %h",
								exp_w[7:0], m_tdata[7:0], exp_w[39:8], m_tdata[39:8]);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				idx = s_tdata[4:0];
				s   = s_tdata[36:5];
				case (op_t'(s_tuser))
				OP_LOAD: begin
					mean_tab[idx] = s_tdata[68:37];
					dev_tab[idx]  = s_tdata[100:69];
				end
				OP_TS: expected_words.push_back({s, quantize(s, ts_inv, ts_zp)});
				OP_STAT: begin
					norm = z_score(s, mean_tab[idx], dev_tab[idx]);
					expected_words.push_back({norm, quantize(norm, stat_inv, stat_zp)});
				end
				default: ;
				endcase
			end
		end
	end

endmodule

// ===== tb/sv/tb_feature_normalize_quantize_int8_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_feature_normalize_quantize_int8_top
// stimulus and verdict for the normalizer and int8 quantizer
// ----------------------------------------------------------------------------
// loads every table entry first, then runs directed and random words over
// several register settings, with bursty input and a stalling receiver
module tb_feature_normalize_quantize_int8_top;
	import fnq_pkg::*;

	localparam int LATENCY = 37;
	localparam longint LIMIT = 200000;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [103:0] s_tdata;   // feature_index[4:0], sample_value[36:5],
	                         // mean_entry[68:37], deviation_entry[100:69]
	logic [1:0]   s_tuser;   // operation[1:0]
	logic         m_tvalid;
	logic         m_tready;
	logic [39:0]  m_tdata;   // quantized[7:0], normalized[39:8]
	logic         cfg_we;
	logic [1:0]   cfg_index;
	logic [31:0]  cfg_data;
	int           fail_count;
	int           pending;
	longint       cycles;
	bit           stall_on;

	feature_normalize_quantize_int8_top DUT (.*);

	fnq_checker u_checker (.*);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// cycle limit as a watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// receiver stalls in runs, sometimes long quiet stretches without stalls
	always @(negedge clk) begin
		if (!stall_on)
			m_tready <= 1'b1;
		else
			m_tready <= ($urandom_range(0, 3) != 0);
	end

	always @(posedge clk)
		if ($urandom_range(0, 199) == 0)
			stall_on <= ~stall_on;

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// one word, sent at a falling edge and held until accepted
	task automatic send_word(input op_t op, input logic [4:0] idx, input logic [31:0] s,
			input logic [31:0] m, input logic [31:0] dev);
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {3'b0, dev, m, s, idx};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// bursty gaps between words
	int burst_left;
	task automatic gap();
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		s_tvalid <= 1'b0;
		repeat ($urandom_range(1, 6)) @(negedge clk);
		burst_left = $urandom_range(0, 20);
	endtask

	function automatic logic [31:0] rnd_sample();
		case ($urandom_range(0, 5))
		0: return 32'h8000_0000;
		1: return 32'h7FFF_FFFF;
		2: return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
		3: return 32'($signed($urandom_range(0, 2000)) - 1000);
		default: return $urandom();
		endcase
	endfunction

	function automatic logic [31:0] rnd_dev();
		case ($urandom_range(0, 4))
		0: return 32'd0;
		1: return 32'd1;
		2: return 32'hFFFF_FFFF;
		3: return $urandom_range(1, 32'h0004_0000);
		default: return $urandom();
		endcase
	endfunction

	// wait for drain, plus latency for trailing load words
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	task automatic random_phase(input int n);
		op_t op;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 9))
			0, 1:       op = OP_LOAD;
			2, 3, 4:    op = OP_TS;
			9:          op = OP_NONE;
			default:    op = OP_STAT;
			endcase
			send_word(op, 5'($urandom_range(0, 31)), rnd_sample(), rnd_sample(), rnd_dev());
			gap();
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = '0;
		m_tready  = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		cycles    = 0;
		stall_on  = 1'b0;
		burst_left = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// every table entry written before any statistic read
		for (int f = 0; f < STAT_FEATURES; f++)
			send_word(OP_LOAD, 5'(f), $urandom(), rnd_sample(), rnd_dev());

		// directed: reset settings, extremes, zero deviation, saturation
		send_word(OP_TS, 0, 32'h8000_0000, 0, 0);
		send_word(OP_TS, 31, 32'h7FFF_FFFF, 0, 0);
		send_word(OP_TS, 0, 32'h0000_8000, 0, 0);   // half rounds to even 0
		send_word(OP_TS, 0, 32'h0001_8000, 0, 0);   // half rounds to 2
		send_word(OP_TS, 0, 32'hFFFE_8000, 0, 0);   // negative half
		send_word(OP_LOAD, 3, 32'hFFFF_FFFF, 32'h8000_0000, 32'd0);
		send_word(OP_STAT, 3, 32'h7FFF_FFFF, 0, 0); // huge quotient, saturates
		send_word(OP_LOAD, 4, 0, 32'h7FFF_FFFF, 32'd1);
		send_word(OP_STAT, 4, 32'h8000_0000, 0, 0); // negative saturation
		send_word(OP_LOAD, 5, 0, 32'h0000_0000, 32'hFFFF_FFFF);
		send_word(OP_STAT, 5, 32'h7FFF_FFFF, 0, 0);
		send_word(OP_NONE, 7, $urandom(), $urandom(), $urandom());
		send_word(OP_STAT, 31, 32'h0003_0000, 0, 0);
		drain();

		write_reg(REG_TS_INV, 32'hFFFF_FFFF);
		write_reg(REG_TS_ZP, 32'h0000_007F);
		write_reg(REG_STAT_INV, 32'd0);
		write_reg(REG_STAT_ZP, 32'hFFFF_FF80);
		send_word(OP_TS, 1, 32'h0000_0001, 0, 0);
		send_word(OP_TS, 1, 32'hFFFF_FFFF, 0, 0);
		send_word(OP_STAT, 4, 32'h1234_5678, 0, 0);
		random_phase(130);
		drain();

		write_reg(REG_TS_INV, 32'd0);
		write_reg(REG_TS_ZP, 32'h0000_0080);
		write_reg(REG_STAT_INV, 32'h0000_0001);
		write_reg(REG_STAT_ZP, 32'h0000_007F);
		random_phase(130);
		drain();

		for (int p = 0; p < 2; p++) begin
			write_reg(REG_TS_INV, $urandom_range(0, 32'h0010_0000));
			write_reg(REG_TS_ZP, $urandom());
			write_reg(REG_STAT_INV, $urandom_range(0, 32'h0020_0000));
			write_reg(REG_STAT_ZP, $urandom());
			random_phase(130);
			drain();
		end

		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
design/fnq_pkg.sv
design/fnq_div_cell.sv
design/fnq_quant.sv
design/feature_normalize_quantize_int8_top.sv
design/fnq_checker.sv
tb/sv/fnq_checker.sv
tb/sv/tb_feature_normalize_quantize_int8_top.sv
